FILE: rtl/core/pjtt_pkg.sv
package pjtt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam int TIME_W = 63;
   localparam int PER_W  = 31;
   localparam int ID_W   = 16;
   localparam int US_W   = 20;
   localparam int P_W    = PER_W + US_W;

   localparam logic [US_W-1:0]   US_PER_SEC = US_W'(1000000);
   localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;

   localparam logic [2:0] ST_STORED    = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_DELETED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FIRED     = 3'd4;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ID_W-1:0]   job_id;
      logic [TIME_W-1:0] start_time;
      logic [PER_W-1:0]  repeat_seconds;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic              fired;
      logic [ID_W-1:0]   fired_id;
      logic              next_valid;
      logic [TIME_W-1:0] next_start;
      logic              last;
   } rsp_type;

endpackage

FILE: rtl/core/periodic_job_timer_table.sv
// Periodic job timer table.
// Request beats arrive on req_valid/req_ready with a req_type payload: insert
// a job, delete a job by id, or a time tick. Response beats leave on
// rsp_valid/rsp_ready as rsp_type. Insert and delete give one beat each; a
// tick gives one beat per fired job in slot order and then a summary beat
// with last set and the earliest pending start. Mode 3 is taken and dropped.
// One request is worked on at a time; req_ready is high only between
// requests. An insert scans the slots in use for an idle one, and a delete
// or a tick scans the table one slot per memory read. Each fired periodic
// job also passes through the shared one-bit-per-cycle remainder unit over
// the 63-bit time difference to find its next start. Responses go out
// through one output register, so a finished response may wait there while
// the next request is accepted; a stalled receiver holds the scan until
// that register frees up.
// Synchronous reset empties the table and drops any pending response; slot
// contents are not cleared and are read only after an insert has written them.
module periodic_job_timer_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pjtt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pjtt_pkg::rsp_type rsp_data
);
   import pjtt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_READ, S_EVAL, S_MUL, S_DIV, S_FIX, S_EMIT
   } state_type;

   state_type               state_ff, state_in, ret_ff, ret_in;
   logic [CNT_W-1:0]        idx_ff, idx_in, in_use_ff, in_use_in;
   req_type                 op_ff, op_in;
   logic [TABLE_DEPTH-1:0]  idle_ff, idle_in;
   logic                    nv_ff, nv_in;
   logic [TIME_W-1:0]       ns_ff, ns_in;
   rsp_type                 pend_ff, pend_in, rsp_data_ff, rsp_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [P_W-1:0]          p_ff, p_in, rem_ff, rem_in;
   logic [TIME_W-1:0]       dvd_ff, dvd_in;
   logic [5:0]              bit_ff, bit_in;

   logic [ID_W-1:0]         mem_id [TABLE_DEPTH];
   logic [TIME_W-1:0]       mem_start [TABLE_DEPTH];
   logic [PER_W-1:0]        mem_period [TABLE_DEPTH];
   logic [ID_W-1:0]         rd_id_ff;
   logic [TIME_W-1:0]       rd_start_ff;
   logic [PER_W-1:0]        rd_period_ff;

   logic                    wr_all, wr_start;
   logic [IDX_W-1:0]        addr;
   logic [P_W:0]            rem_sh;
   logic [P_W-1:0]          gap;
   logic [TIME_W:0]         sum;
   logic [TIME_W-1:0]       fix_val;

   function automatic rsp_type make_rsp(logic [2:0] status, logic fired,
                                        logic [ID_W-1:0] fid, logic nv,
                                        logic [TIME_W-1:0] ns, logic last);
      rsp_type r;
      r.status     = status;
      r.fired      = fired;
      r.fired_id   = fid;
      r.next_valid = nv;
      r.next_start = ns;
      r.last       = last;
      return r;
   endfunction

   assign addr      = idx_ff[IDX_W-1:0];
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rem_sh  = {rem_ff, dvd_ff[TIME_W-1]};
   assign gap     = p_ff - rem_ff;
   assign sum     = {1'b0, op_ff.now_time} + (TIME_W + 1)'(gap);
   assign fix_val = (rem_ff == '0) ? op_ff.now_time :
                    (sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0]);

   always_ff @(posedge clock) begin
      if (wr_all) begin
         mem_id[addr]     <= op_ff.job_id;
         mem_period[addr] <= op_ff.repeat_seconds;
      end
      if (wr_all || wr_start) begin
         mem_start[addr] <= wr_all ? op_ff.start_time : fix_val;
      end
      rd_id_ff     <= mem_id[addr];
      rd_start_ff  <= mem_start[addr];
      rd_period_ff <= mem_period[addr];
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      idx_in       = idx_ff;
      in_use_in    = in_use_ff;
      op_in        = op_ff;
      idle_in      = idle_ff;
      nv_in        = nv_ff;
      ns_in        = ns_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      p_in         = p_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      bit_in       = bit_ff;
      wr_all       = 1'b0;
      wr_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_data;
               idx_in = '0;
               nv_in  = 1'b0;
               ns_in  = '0;
               case (req_data.mode)
                  MODE_INSERT: state_in = S_SCAN;
                  MODE_DELETE: state_in = S_READ;
                  MODE_TICK:   state_in = S_READ;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (idx_ff == in_use_ff) begin
               ret_in   = S_IDLE;
               state_in = S_EMIT;
               if (in_use_ff == CNT_W'(TABLE_DEPTH)) begin
                  pend_in = make_rsp(ST_FULL, 1'b0, '0, 1'b0, '0, 1'b1);
               end else begin
                  wr_all        = 1'b1;
                  in_use_in     = in_use_ff + 1'b1;
                  idle_in[addr] = 1'b0;
                  pend_in = make_rsp(ST_STORED, 1'b0, '0, 1'b0, '0, 1'b1);
               end
            end else if (idle_ff[addr]) begin
               wr_all        = 1'b1;
               idle_in[addr] = 1'b0;
               ret_in        = S_IDLE;
               state_in      = S_EMIT;
               pend_in = make_rsp(ST_STORED, 1'b0, '0, 1'b0, '0, 1'b1);
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_READ: begin
            if (idx_ff == in_use_ff) begin
               ret_in   = S_IDLE;
               state_in = S_EMIT;
               if (op_ff.mode == MODE_DELETE) begin
                  pend_in = make_rsp(ST_NOT_FOUND, 1'b0, '0, 1'b0, '0, 1'b1);
               end else begin
                  pend_in = make_rsp(ST_FIRED, 1'b0, '0, nv_ff, ns_ff, 1'b1);
               end
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (op_ff.mode == MODE_DELETE) begin
               if (rd_id_ff == op_ff.job_id) begin
                  idle_in[addr] = 1'b1;
                  ret_in        = S_IDLE;
                  state_in      = S_EMIT;
                  pend_in = make_rsp(ST_DELETED, 1'b0, '0, 1'b0, '0, 1'b1);
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end else if (idle_ff[addr]) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end else if (rd_start_ff < op_ff.now_time) begin
               pend_in  = make_rsp(ST_FIRED, 1'b1, rd_id_ff, 1'b0, '0, 1'b0);
               state_in = S_EMIT;
               if (rd_period_ff == '0) begin
                  idle_in[addr] = 1'b1;
                  idx_in        = idx_ff + 1'b1;
                  ret_in        = S_READ;
               end else begin
                  ret_in = S_MUL;
               end
            end else begin
               if (!nv_ff || rd_start_ff < ns_ff) begin
                  nv_in = 1'b1;
                  ns_in = rd_start_ff;
               end
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_MUL: begin
            p_in     = P_W'(rd_period_ff) * P_W'(US_PER_SEC);
            dvd_in   = op_ff.now_time - rd_start_ff;
            rem_in   = '0;
            bit_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_sh >= {1'b0, p_ff}) begin
               rem_in = P_W'(rem_sh - {1'b0, p_ff});
            end else begin
               rem_in = rem_sh[P_W-1:0];
            end
            dvd_in = {dvd_ff[TIME_W-2:0], 1'b0};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 6'(TIME_W - 1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            wr_start = 1'b1;
            if (!nv_ff || fix_val < ns_ff) begin
               nv_in = 1'b1;
               ns_in = fix_val;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_READ;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         idx_ff       <= '0;
         in_use_ff    <= '0;
         nv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         idx_ff       <= idx_in;
         in_use_ff    <= in_use_in;
         nv_ff        <= nv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      idle_ff     <= idle_in;
      ns_ff       <= ns_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
      p_ff        <= p_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      bit_ff      <= bit_in;
   end

endmodule

FILE: rtl/core/pjtt_checker.sv
module pjtt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input pjtt_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pjtt_pkg::rsp_type rsp_data
);
   import pjtt_pkg::*;

   // A stalled response beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // A request that does real work closes the request channel.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_data.mode == MODE_INSERT || req_data.mode == MODE_DELETE ||
       req_data.mode == MODE_TICK) |=> !req_ready)
      else $error("request taken while busy");

   // A fired-job beat is never the final beat of its request, has status ST_FIRED and no next start.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fired |-> !rsp_data.last &&
      rsp_data.status == ST_FIRED && !rsp_data.next_valid)
      else $error("malformed fired-job beat");

   // Only fired-job beats leave last clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.fired)
      else $error("non-final beat without a fired job");

   // Insert and delete answers carry no schedule information.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_FIRED |->
      !rsp_data.next_valid && rsp_data.next_start == '0 && rsp_data.fired_id == '0)
      else $error("table answer carries schedule data");

endmodule

bind periodic_job_timer_table pjtt_checker u_pjtt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
